// ===== src/gioj_pkg.sv =====
// Shared types and constants of the grouped interval overlap join unit.
package gioj_pkg;

    // Buffered records per group
    localparam int GROUP_DEPTH = 32;
    // Buffer address width and count width (count reaches GROUP_DEPTH)
    localparam int IDX_W = $clog2(GROUP_DEPTH);
    localparam int CNT_W = $clog2(GROUP_DEPTH + 1);

    // Result status codes
    typedef enum logic [1:0] {
        STAT_PAIR  = 2'd0,
        STAT_ORDER = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_FLUSH
    } state_t;

    // One buffered segment record
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  chr;
        logic        copy;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
    } entry_t;

    // Write request into the group buffer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    // Result fields owned by the buffered side (plus status)
    typedef struct packed {
        logic [15:0] first_id;
        logic [7:0]  chr;
        logic        first_copy;
        logic [31:0] ostart;
        logic [31:0] oend;
        status_t     status;
    } result_t;

endpackage

// ===== src/grouped_interval_overlap_join_unit.sv =====
// Top level of the grouped interval overlap join unit: sequencer, compare pipe, result register.
//
//  channel | direction | ports      | moves
//  --------+-----------+------------+------------------------------------------
//  s_      | in        | valid/ready| one segment record request
//  m_      | out       | valid/ready| one overlap pair or status marker request
//
// A record is taken only once the previous one has been compared with the N records
// already buffered in its group (N up to GROUP_DEPTH, 32 by default): the buffer read
// port hands out one entry per cycle, unless the scan is stalled, to a compare pipe of three stages.
// s_ready is high only while the sequencer is idle; m_ready low stalls the scan.
// aresetn (synchronous) clears sequencer, counts and flags, not the buffer contents.
// After an order error the unit keeps accepting records and drops them until reset.
module grouped_interval_overlap_join_unit import gioj_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // record channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_individual_id,
    input  logic [7:0]  s_chromosome,
    input  logic        s_haplotype_copy,
    input  logic [31:0] s_start_pos,
    input  logic [31:0] s_end_pos,
    input  logic [23:0] s_group_index,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_first_individual,
    output logic [15:0] m_second_individual,
    output logic [7:0]  m_pair_chromosome,
    output logic [31:0] m_overlap_start,
    output logic [31:0] m_overlap_end,
    output logic [32:0] m_overlap_length,
    output logic        m_first_copy,
    output logic        m_second_copy,
    output logic [1:0]  m_status,
    output logic        m_last_of_run
);

    state_t state_reg, state_next;

    // latched record
    entry_t      in_reg;
    logic [23:0] in_grp_reg;

    // group state
    logic [23:0]      cur_grp_reg;
    logic             seen_reg;
    logic             halted_reg;
    logic [CNT_W-1:0] count_reg;
    logic             full_reg;

    // scan pipe
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             rd_vld_reg;
    result_t          cand_reg;
    logic             cand_skip_reg;
    logic             cand_vld_reg;
    result_t          pend_reg;
    logic             pend_vld_reg;

    // result register
    logic        m_valid_reg;
    result_t     m_res_reg;
    logic [32:0] m_len_reg;
    logic [15:0] m_second_reg;
    logic        m_second_copy_reg;
    logic        m_last_reg;

    // control
    logic             accept;
    logic             out_free;
    logic             cand_hit;
    logic             adv;
    logic             issue;
    logic             scan_done;
    logic             order_err;
    logic             new_grp;
    logic [CNT_W-1:0] eff_cnt;
    logic             room;
    logic             push;
    logic             push_last;
    logic             load_err;
    logic             load_mark;
    logic             load_cand;
    logic             s_ready_c;
    mem_wr_t          mem_wr;
    entry_t           rd_data;
    logic [31:0]      cmp_start;
    logic [31:0]      cmp_end;
    result_t          err_mark;
    result_t          full_mark;

    // group buffer
    gioj_mem u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // handshake and pipe control
    assign accept    = s_valid && s_ready_c;
    assign out_free  = !m_valid_reg || m_ready;
    assign cand_hit  = cand_vld_reg && !cand_skip_reg && (cand_reg.ostart <= cand_reg.oend);
    assign adv       = !(cand_hit && pend_vld_reg && !out_free);
    assign issue     = (state_reg == S_SCAN) && adv && (rd_idx_reg < scan_cnt_reg);
    assign scan_done = (rd_idx_reg == scan_cnt_reg) && !rd_vld_reg && !cand_vld_reg;

    // group decision for the latched record
    assign order_err = seen_reg && (in_grp_reg < cur_grp_reg);
    assign new_grp   = !seen_reg || (in_grp_reg > cur_grp_reg);
    assign eff_cnt   = new_grp ? '0 : count_reg;
    assign room      = eff_cnt < CNT_W'(GROUP_DEPTH);

    // buffer write of the new record
    always_comb begin
        mem_wr.we   = (state_reg == S_CHECK) && !order_err && room;
        mem_wr.addr = eff_cnt[IDX_W-1:0];
        mem_wr.data = in_reg;
    end

    // interval intersection of the entry just read
    assign cmp_start = (rd_data.start_pos > in_reg.start_pos) ? rd_data.start_pos
                                                               : in_reg.start_pos;
    assign cmp_end   = (rd_data.end_pos < in_reg.end_pos) ? rd_data.end_pos
                                                           : in_reg.end_pos;

    // status markers
    always_comb begin
        err_mark        = '0;
        err_mark.status = STAT_ORDER;
        full_mark        = '0;
        full_mark.status = STAT_FULL;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && !halted_reg) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = order_err ? S_FLUSH : S_SCAN;
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_MARK;
                end
            end
            S_MARK: begin
                if (!full_reg || !pend_vld_reg || out_free) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!pend_vld_reg || out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready_c = 1'b0;
        push      = 1'b0;
        push_last = 1'b0;
        load_err  = 1'b0;
        load_mark = 1'b0;
        load_cand = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready_c = 1'b1;
            end
            S_CHECK: begin
                load_err = order_err;
            end
            S_SCAN: begin
                load_cand = adv && cand_hit;
                push      = adv && cand_hit && pend_vld_reg;
            end
            S_MARK: begin
                if (full_reg) begin
                    if (!pend_vld_reg) begin
                        load_mark = 1'b1;
                    end else if (out_free) begin
                        push      = 1'b1;
                        load_mark = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (pend_vld_reg && out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign s_ready = s_ready_c;

    // sequencer and group state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cur_grp_reg <= '0;
            seen_reg    <= 1'b0;
            halted_reg  <= 1'b0;
            count_reg   <= '0;
            full_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            scan_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CHECK) begin
                if (order_err) begin
                    halted_reg <= 1'b1;
                end else begin
                    cur_grp_reg  <= in_grp_reg;
                    seen_reg     <= 1'b1;
                    count_reg    <= room ? eff_cnt + CNT_W'(1) : eff_cnt;
                    full_reg     <= !room;
                    scan_cnt_reg <= eff_cnt;
                    rd_idx_reg   <= '0;
                end
            end else if (issue) begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
        end
    end

    // record latch
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg.id        <= s_individual_id;
            in_reg.chr       <= s_chromosome;
            in_reg.copy      <= s_haplotype_copy;
            in_reg.start_pos <= s_start_pos;
            in_reg.end_pos   <= s_end_pos;
            in_grp_reg       <= s_group_index;
        end
    end

    // compare pipe valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            cand_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else begin
            if (adv) begin
                rd_vld_reg   <= issue;
                cand_vld_reg <= rd_vld_reg;
            end
            if (load_err || load_mark || load_cand) begin
                pend_vld_reg <= 1'b1;
            end else if (push) begin
                pend_vld_reg <= 1'b0;
            end
        end
    end

    // compare pipe payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            cand_reg.first_id   <= rd_data.id;
            cand_reg.chr        <= rd_data.chr;
            cand_reg.first_copy <= rd_data.copy;
            cand_reg.ostart     <= cmp_start;
            cand_reg.oend       <= cmp_end;
            cand_reg.status     <= STAT_PAIR;
            cand_skip_reg       <= (rd_data.id == in_reg.id);
        end
        if (load_err) begin
            pend_reg <= err_mark;
        end else if (load_mark) begin
            pend_reg <= full_mark;
        end else if (load_cand) begin
            pend_reg <= cand_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_res_reg         <= pend_reg;
            m_len_reg         <= (pend_reg.status == STAT_PAIR)
                                 ? {1'b0, pend_reg.oend} - {1'b0, pend_reg.ostart} + 33'd1
                                 : '0;
            m_second_reg      <= in_reg.id;
            m_second_copy_reg <= in_reg.copy;
            m_last_reg        <= push_last;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_first_individual  = m_res_reg.first_id;
    assign m_second_individual = m_second_reg;
    assign m_pair_chromosome   = m_res_reg.chr;
    assign m_overlap_start     = m_res_reg.ostart;
    assign m_overlap_end       = m_res_reg.oend;
    assign m_overlap_length    = m_len_reg;
    assign m_first_copy        = m_res_reg.first_copy;
    assign m_second_copy       = m_second_copy_reg;
    assign m_status            = m_res_reg.status;
    assign m_last_of_run       = m_last_reg;

`ifndef SYNTHESIS
    // a result is never pushed over one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> out_free)
        else $error("result pushed while output register busy");
    // no new record while a result is still pending
    assert property (@(posedge aclk) disable iff (!aresetn) s_ready |-> !pend_vld_reg)
        else $error("record accepted with a pending result");
    // fill count bounded by the buffer depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(GROUP_DEPTH))
        else $error("group count beyond buffer depth");
    // halt holds until reset
    assert property (@(posedge aclk) disable iff (!aresetn) halted_reg |=> halted_reg)
        else $error("halt released without reset");
    // markers close the run of their record
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_PAIR) |-> m_last_of_run)
        else $error("status marker not last of run");
`endif

endmodule

// ===== src/gioj_mem.sv =====
// Group buffer: one write port, one registered read port.
module gioj_mem import gioj_pkg::*; (
    input  logic             aclk,
    input  mem_wr_t          wr,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem_reg [GROUP_DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // read port, data registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the grouped interval overlap join unit.
`timescale 1ns / 1ps

module tb_top;
    import gioj_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LONG_HOLD     = 600;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 150;
    localparam int SCRIPT_ROWS   = 21;
    localparam int HEAD_ROWS     = 16;

    // How a scripted row is checked
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        ONE_RESULT
    } row_check_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  chr;
        logic        copy;
        logic [31:0] first_base;
        logic [31:0] last_base;
        logic [23:0] grp;
    } segment_t;

    typedef struct packed {
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic [7:0]  chr;
        logic [31:0] ov_start;
        logic [31:0] ov_end;
        logic [32:0] ov_len;
        logic        first_copy;
        logic        second_copy;
        status_t     status;
        logic        last;
    } pair_result_t;

    typedef struct {
        int unsigned  reps;
        segment_t     seg;
        row_check_t   chk;
        pair_result_t want;
    } stim_row_t;

    localparam pair_result_t NO_PAIR = '0;

    // Directed script: head rows run first, tail rows (order error, halt) run last
    stim_row_t script [SCRIPT_ROWS] = '{
        // first record after reset opens group 0
        '{1, '{16'h0000, 8'h00, 1'b0, 32'h0, 32'hFFFF_FFFF, 24'h0}, NO_RESULT, NO_PAIR},
        // widest possible overlap, length needs the 33rd bit
        '{1, '{16'hFFFF, 8'hFF, 1'b1, 32'h0, 32'hFFFF_FFFF, 24'h0}, ONE_RESULT,
          '{16'h0000, 16'hFFFF, 8'h00, 32'h0, 32'hFFFF_FFFF, 33'h1_0000_0000,
            1'b0, 1'b1, STAT_PAIR, 1'b1}},
        // same individual as a buffered record is skipped
        '{1, '{16'h0000, 8'h05, 1'b1, 32'd100, 32'd200, 24'h0}, BY_MODEL, NO_PAIR},
        // start after end: stored but never overlaps
        '{1, '{16'h0007, 8'h11, 1'b0, 32'd300, 32'd100, 24'h0}, BY_MODEL, NO_PAIR},
        // single-base interval
        '{1, '{16'h0008, 8'h22, 1'b1, 32'd200, 32'd200, 24'h0}, BY_MODEL, NO_PAIR},
        // top base only
        '{1, '{16'h0009, 8'h33, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0}, BY_MODEL, NO_PAIR},
        // higher group empties the buffer
        '{1, '{16'h1234, 8'h01, 1'b1, 32'd50, 32'd60, 24'h1}, NO_RESULT, NO_PAIR},
        // adjacent, not touching
        '{1, '{16'h4321, 8'h02, 1'b0, 32'd61, 32'd70, 24'h1}, NO_RESULT, NO_PAIR},
        // touches both ends by one base
        '{1, '{16'h5555, 8'h55, 1'b1, 32'd60, 32'd61, 24'h1}, BY_MODEL, NO_PAIR},
        '{1, '{16'hAAAA, 8'hAA, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 24'h1}, BY_MODEL, NO_PAIR},
        '{1, '{16'h00FF, 8'h0F, 1'b0, 32'd10, 32'd20, 24'h000100}, BY_MODEL, NO_PAIR},
        '{1, '{16'hFF00, 8'hF0, 1'b1, 32'd15, 32'd25, 24'h000100}, BY_MODEL, NO_PAIR},
        // fill the buffer with one individual, so no pairs come out
        '{32, '{16'h0042, 8'h03, 1'b0, 32'd1000, 32'd2000, 24'h80_0000}, NO_RESULT, NO_PAIR},
        // buffer full, no pairs: marker only
        '{1, '{16'h0042, 8'h04, 1'b1, 32'd1000, 32'd2000, 24'h80_0000}, ONE_RESULT,
          '{16'h0, 16'h0042, 8'h0, 32'h0, 32'h0, 33'h0, 1'b0, 1'b1, STAT_FULL, 1'b1}},
        // buffer full with every entry overlapping: most results per request
        '{1, '{16'h0043, 8'h05, 1'b0, 32'd1500, 32'd1600, 24'h80_0000}, BY_MODEL, NO_PAIR},
        '{1, '{16'h0044, 8'h06, 1'b1, 32'd1700, 32'd1600, 24'h80_0000}, ONE_RESULT,
          '{16'h0, 16'h0044, 8'h0, 32'h0, 32'h0, 33'h0, 1'b0, 1'b1, STAT_FULL, 1'b1}},
        // tail: top group, one pair, then a lower index halts the unit
        '{1, '{16'h0001, 8'h07, 1'b0, 32'd0, 32'd10, 24'hFF_FFFF}, NO_RESULT, NO_PAIR},
        '{1, '{16'h0002, 8'h08, 1'b1, 32'd5, 32'd15, 24'hFF_FFFF}, ONE_RESULT,
          '{16'h0001, 16'h0002, 8'h07, 32'd5, 32'd10, 33'd6, 1'b0, 1'b1, STAT_PAIR, 1'b1}},
        '{1, '{16'hBEEF, 8'h99, 1'b1, 32'd5, 32'd15, 24'hFF_FFFE}, ONE_RESULT,
          '{16'h0, 16'hBEEF, 8'h0, 32'h0, 32'h0, 33'h0, 1'b0, 1'b1, STAT_ORDER, 1'b1}},
        // halted: requests are taken and dropped
        '{1, '{16'h0003, 8'h09, 1'b0, 32'd0, 32'd10, 24'hFF_FFFF}, NO_RESULT, NO_PAIR},
        '{1, '{16'h0004, 8'h0A, 1'b1, 32'd0, 32'd10, 24'h0}, NO_RESULT, NO_PAIR}
    };

    logic        aclk;
    logic        aresetn            = 1'b0;
    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic [15:0] s_individual_id    = '0;
    logic [7:0]  s_chromosome       = '0;
    logic        s_haplotype_copy   = 1'b0;
    logic [31:0] s_start_pos        = '0;
    logic [31:0] s_end_pos          = '0;
    logic [23:0] s_group_index      = '0;
    logic        m_valid;
    logic        m_ready            = 1'b0;
    logic [15:0] m_first_individual;
    logic [15:0] m_second_individual;
    logic [7:0]  m_pair_chromosome;
    logic [31:0] m_overlap_start;
    logic [31:0] m_overlap_end;
    logic [32:0] m_overlap_length;
    logic        m_first_copy;
    logic        m_second_copy;
    logic [1:0]  m_status;
    logic        m_last_of_run;

    // Predictor state: open group and its buffered segments
    segment_t     held [GROUP_DEPTH];
    int unsigned  held_count  = 0;
    logic [23:0]  open_group  = '0;
    bit           group_open  = 1'b0;
    bit           stopped     = 1'b0;
    pair_result_t join_out [$];

    // Results owed for requests already taken, oldest first
    pair_result_t owed_pairs [$];

    int unsigned  mismatches    = 0;
    int unsigned  cycle_count   = 0;
    bit           tx_steady     = 1'b0;
    bit           rx_steady     = 1'b0;
    bit           hold_results  = 1'b0;

    grouped_interval_overlap_join_unit dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_individual_id     (s_individual_id),
        .s_chromosome        (s_chromosome),
        .s_haplotype_copy    (s_haplotype_copy),
        .s_start_pos         (s_start_pos),
        .s_end_pos           (s_end_pos),
        .s_group_index       (s_group_index),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_first_individual  (m_first_individual),
        .m_second_individual (m_second_individual),
        .m_pair_chromosome   (m_pair_chromosome),
        .m_overlap_start     (m_overlap_start),
        .m_overlap_end       (m_overlap_end),
        .m_overlap_length    (m_overlap_length),
        .m_first_copy        (m_first_copy),
        .m_second_copy       (m_second_copy),
        .m_status            (m_status),
        .m_last_of_run       (m_last_of_run)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Work out the results one segment causes; fills join_out
    function automatic void join_segment(input segment_t rec);
        logic [31:0]  lo, hi;
        pair_result_t r;
        join_out.delete();
        if (stopped)
            return;
        // lower group index: order error, then dead until reset
        if (group_open && rec.grp < open_group) begin
            r = '0;
            r.second_id   = rec.id;
            r.second_copy = rec.copy;
            r.status      = STAT_ORDER;
            r.last        = 1'b1;
            join_out = {join_out, r};
            stopped = 1'b1;
            return;
        end
        if (!group_open || rec.grp > open_group) begin
            held_count = 0;
            open_group = rec.grp;
            group_open = 1'b1;
        end
        // compare against buffered entries in buffer order
        for (int i = 0; i < held_count; i++) begin
            if (held[i].id == rec.id)
                continue;
            lo = (held[i].first_base > rec.first_base) ? held[i].first_base : rec.first_base;
            hi = (held[i].last_base < rec.last_base) ? held[i].last_base : rec.last_base;
            if (lo > hi)
                continue;
            r = '{held[i].id, rec.id, held[i].chr, lo, hi, {1'b0, hi} - {1'b0, lo} + 33'd1,
                  held[i].copy, rec.copy, STAT_PAIR, 1'b0};
            join_out = {join_out, r};
        end
        if (held_count < GROUP_DEPTH) begin
            held[held_count] = rec;
            held_count++;
        end else begin
            r = '0;
            r.second_id   = rec.id;
            r.second_copy = rec.copy;
            r.status      = STAT_FULL;
            join_out = {join_out, r};
        end
        // flag the final result of this request
        if (join_out.size() > 0)
            join_out[join_out.size() - 1].last = 1'b1;
    endfunction

    // Offer one segment request, wait for it to be taken, book its results
    task automatic feed(input segment_t rec, input row_check_t chk, input pair_result_t want);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_individual_id  <= rec.id;
        s_chromosome     <= rec.chr;
        s_haplotype_copy <= rec.copy;
        s_start_pos      <= rec.first_base;
        s_end_pos        <= rec.last_base;
        s_group_index    <= rec.grp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        join_segment(rec);
        case (chk)
            BY_MODEL: begin
                owed_pairs = {owed_pairs, join_out};
            end
            ONE_RESULT: begin
                owed_pairs = {owed_pairs, want};
            end
            default: begin
            end
        endcase
    endtask

    // Sender stands back until everything owed has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (owed_pairs.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s expected %0h got %0h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    // Result side: random stalls, steady stretches, one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_results = 1'b0;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Compare every result taken against the oldest one owed
    always @(posedge aclk) begin : result_check
        pair_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_pairs.size() == 0) begin
                $display("%0t ns: result with nothing owed: second %0h status %0d",
                         $time, m_second_individual, m_status);
                mismatches++;
            end else begin
                want = owed_pairs.pop_front();
                check_field("first_individual", want.first_id, m_first_individual);
                check_field("second_individual", want.second_id, m_second_individual);
                check_field("pair_chromosome", want.chr, m_pair_chromosome);
                check_field("overlap_start", want.ov_start, m_overlap_start);
                check_field("overlap_end", want.ov_end, m_overlap_end);
                check_field("overlap_length", want.ov_len, m_overlap_length);
                check_field("first_copy", want.first_copy, m_first_copy);
                check_field("second_copy", want.second_copy, m_second_copy);
                check_field("status", want.status, m_status);
                check_field("last_of_run", want.last, m_last_of_run);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_pairs.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        segment_t    rec;
        logic [23:0] grp;
        logic [31:0] base;
        int unsigned step, group_size, sent;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed head of the script
        for (int r = 0; r < HEAD_ROWS; r++)
            for (int n = 0; n < script[r].reps; n++)
                feed(script[r].seg, script[r].chk, script[r].want);
        drain_results();

        // random groups, ascending; receiver holds off at the start
        hold_results = 1'b1;
        grp  = 24'h80_0000;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            step = 1 + $urandom_range(0, (1 << $urandom_range(0, 16)) - 1);
            if (int'(grp) + step <= 24'hFF_FFF0)
                grp = grp + step[23:0];
            group_size = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36)
                                                      : $urandom_range(1, 8);
            base      = $urandom;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < group_size && sent < RANDOM_ITEMS; k++) begin
                rec.id   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(1, 12));
                rec.chr  = 8'($urandom);
                rec.copy = 1'($urandom);
                rec.grp  = grp;
                rec.first_base = base + $urandom_range(0, 400);
                rec.last_base  = rec.first_base + $urandom_range(0, 400);
                // occasional noise and reversed intervals
                case ($urandom_range(0, 9))
                    0: begin
                        rec.first_base = $urandom;
                        rec.last_base  = $urandom;
                    end
                    1: rec.last_base = rec.first_base - $urandom_range(1, 50);
                    default: begin
                    end
                endcase
                feed(rec, BY_MODEL, NO_PAIR);
                sent++;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_results();

        // order error and halted requests close the run
        for (int r = HEAD_ROWS; r < SCRIPT_ROWS; r++)
            for (int n = 0; n < script[r].reps; n++)
                feed(script[r].seg, script[r].chk, script[r].want);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && owed_pairs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
